FILE: rtl/core/ahp_pkg.sv
// Shared types, constants and the sampling rate table of the ADTS header parser.
package ahp_pkg;

  localparam int COUNT_WIDTH_DEF = 32;
  localparam int FLEN_W = 13;
  localparam int RATE_W = 17;
  localparam int K8_W = 10;
  localparam int AVG_W = 23;
  localparam int IN_W = 56;
  localparam int OUT_W = 80;
  localparam int RATE_SHIFT = 10;
  localparam logic [10:0] VBR_MARK = 11'h7FF;

  typedef struct packed {
    logic              mpeg_version_bit;
    logic              no_crc;
    logic [2:0]        object_type;
    logic [3:0]        rate_index;
    logic [RATE_W-1:0] sample_rate_hz;
    logic [2:0]        channel_config;
    logic [FLEN_W-1:0] frame_bytes;
    logic [10:0]       fullness;
    logic [1:0]        extra_blocks;
    logic              is_vbr;
  } hdr_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_MUL,
    BK_DIV,
    BK_DONE
  } back_state_t;

  function automatic logic [RATE_W-1:0] rate_of(input logic [3:0] idx);
    logic [RATE_W-1:0] r;
    case (idx)
      4'd0:    r = 17'd96000;
      4'd1:    r = 17'd88200;
      4'd2:    r = 17'd64000;
      4'd3:    r = 17'd48000;
      4'd4:    r = 17'd44100;
      4'd5:    r = 17'd32000;
      4'd6:    r = 17'd24000;
      4'd7:    r = 17'd22050;
      4'd8:    r = 17'd16000;
      4'd9:    r = 17'd12000;
      4'd10:   r = 17'd11025;
      4'd11:   r = 17'd8000;
      4'd12:   r = 17'd7350;
      default: r = 17'd0;
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/core/ahp_front.sv
// Front end: accepts headers, unpacks the fields and keeps the running length sum and frame count.
module ahp_front
  import ahp_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [IN_W-1:0]               in_tdata,
  input  q_stat_t                       q_stat,
  output logic                          push,
  output hdr_t                          push_hdr,
  output logic [COUNT_WIDTH+FLEN_W-1:0] push_sum,
  output logic [COUNT_WIDTH-1:0]        push_count
);

  localparam int SUM_W = COUNT_WIDTH + FLEN_W;

  logic [SUM_W-1:0]       sum_r, sum_nxt;
  logic [COUNT_WIDTH-1:0] count_r, count_nxt;
  logic [SUM_W:0]         sum_add;
  logic                   accept;

  assign in_tready = !q_stat.full;
  assign accept    = in_tvalid && in_tready;
  assign push      = accept;

  always_comb begin
    push_hdr.mpeg_version_bit = in_tdata[43];
    push_hdr.no_crc           = in_tdata[40];
    push_hdr.object_type      = {1'b0, in_tdata[39:38]} + 3'd1;
    push_hdr.rate_index       = in_tdata[37:34];
    push_hdr.sample_rate_hz   = rate_of(in_tdata[37:34]);
    push_hdr.channel_config   = in_tdata[32:30];
    push_hdr.frame_bytes      = in_tdata[25:13];
    push_hdr.fullness         = in_tdata[12:2];
    push_hdr.extra_blocks     = in_tdata[1:0];
    push_hdr.is_vbr           = (in_tdata[12:2] == VBR_MARK);
  end

  assign sum_add = {1'b0, sum_r} + {{(SUM_W + 1 - FLEN_W){1'b0}}, in_tdata[25:13]};

  always_comb begin
    sum_nxt   = sum_r;
    count_nxt = count_r;
    if (accept && (count_r != {COUNT_WIDTH{1'b1}})) begin
      count_nxt = count_r + 1'b1;
      sum_nxt   = sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];
    end
  end

  assign push_sum   = sum_nxt;
  assign push_count = count_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r   <= '0;
      count_r <= '0;
    end else begin
      sum_r   <= sum_nxt;
      count_r <= count_nxt;
    end
  end

  a_count_steps: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && count_r != {COUNT_WIDTH{1'b1}}) |=> count_r == $past(count_r) + 1'b1)
    else $error("frame count did not advance on an accepted word");

  a_sum_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n |=> sum_r >= $past(sum_r))
    else $error("length sum decreased");

endmodule

FILE: rtl/core/ahp_fifo.sv
// Two-entry queue between the front end and the bitrate back end.
module ahp_fifo
  import ahp_pkg::*;
#(
  parameter int DATA_W = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [DATA_W-1:0] push_data,
  input  logic              pop,
  output logic [DATA_W-1:0] pop_data,
  output q_stat_t           stat
);

  localparam int DEPTH = 2;
  localparam int AW = $clog2(DEPTH);
  localparam int FW = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem_r [DEPTH];
  logic [AW-1:0]     wr_ptr_r, rd_ptr_r;
  logic [FW-1:0]     fill_r;

  assign stat.full  = (fill_r == FW'(DEPTH));
  assign stat.empty = (fill_r == '0);
  assign pop_data   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        fill_r <= fill_r + 1'b1;
      end else if (pop && !push) begin
        fill_r <= fill_r - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (!stat.full || pop))
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !stat.empty)
    else $error("queue read while empty");

endmodule

FILE: rtl/core/ahp_back.sv
// Back end: bitrate multiply, bit-serial division by the frame count and the output register.
module ahp_back
  import ahp_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  q_stat_t                       q_stat,
  output logic                          pop,
  input  hdr_t                          pop_hdr,
  input  logic [COUNT_WIDTH+FLEN_W-1:0] pop_sum,
  input  logic [COUNT_WIDTH-1:0]        pop_count,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [OUT_W-1:0]              out_tdata
);

  localparam int SUM_W = COUNT_WIDTH + FLEN_W;
  localparam int PROD_W = SUM_W + K8_W;
  localparam int STEP_W = $clog2(PROD_W);

  back_state_t            state_r, state_nxt;
  hdr_t                   hdr_r, hdr_nxt;
  logic [SUM_W-1:0]       sum_r, sum_nxt;
  logic [COUNT_WIDTH-1:0] div_r, div_nxt;
  logic [PROD_W-1:0]      dvd_r, dvd_nxt;
  logic [COUNT_WIDTH-1:0] rem_r, rem_nxt;
  logic [STEP_W-1:0]      step_r, step_nxt;
  logic                   out_vld_r, out_vld_nxt;
  logic [OUT_W-1:0]       out_data_r, out_data_nxt;
  logic [K8_W-1:0]        k8;
  logic [COUNT_WIDTH:0]   rem_sh, rem_sub;
  logic [AVG_W-1:0]       avg;

  assign k8      = {hdr_r.sample_rate_hz[RATE_W-1:RATE_SHIFT], 3'b000};
  assign rem_sh  = {rem_r, dvd_r[PROD_W-1]};
  assign rem_sub = rem_sh - {1'b0, div_r};
  assign avg     = hdr_r.is_vbr ? '0 : dvd_r[AVG_W-1:0];

  always_comb begin
    state_nxt    = state_r;
    hdr_nxt      = hdr_r;
    sum_nxt      = sum_r;
    div_nxt      = div_r;
    dvd_nxt      = dvd_r;
    rem_nxt      = rem_r;
    step_nxt     = step_r;
    out_vld_nxt  = out_vld_r;
    out_data_nxt = out_data_r;
    pop          = 1'b0;
    if (out_vld_r && out_tready) begin
      out_vld_nxt = 1'b0;
    end
    case (state_r)
      BK_IDLE: begin
        if (!q_stat.empty) begin
          pop       = 1'b1;
          hdr_nxt   = pop_hdr;
          sum_nxt   = pop_sum;
          div_nxt   = pop_count;
          state_nxt = BK_MUL;
        end
      end
      BK_MUL: begin
        dvd_nxt   = {{SUM_W{1'b0}}, k8} * {{K8_W{1'b0}}, sum_r};
        rem_nxt   = '0;
        step_nxt  = '0;
        state_nxt = BK_DIV;
      end
      BK_DIV: begin
        if (!rem_sub[COUNT_WIDTH]) begin
          rem_nxt = rem_sub[COUNT_WIDTH-1:0];
          dvd_nxt = {dvd_r[PROD_W-2:0], 1'b1};
        end else begin
          rem_nxt = rem_sh[COUNT_WIDTH-1:0];
          dvd_nxt = {dvd_r[PROD_W-2:0], 1'b0};
        end
        step_nxt = step_r + 1'b1;
        if (step_r == STEP_W'(PROD_W - 1)) begin
          state_nxt = BK_DONE;
        end
      end
      BK_DONE: begin
        if (!out_vld_r || out_tready) begin
          out_vld_nxt  = 1'b1;
          out_data_nxt = {1'b0, avg, hdr_r.is_vbr, hdr_r.extra_blocks, hdr_r.fullness,
                          hdr_r.frame_bytes, hdr_r.channel_config, hdr_r.sample_rate_hz,
                          hdr_r.rate_index, hdr_r.object_type, hdr_r.no_crc,
                          hdr_r.mpeg_version_bit};
          state_nxt    = BK_IDLE;
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= BK_IDLE;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hdr_r      <= hdr_nxt;
    sum_r      <= sum_nxt;
    div_r      <= div_nxt;
    dvd_r      <= dvd_nxt;
    rem_r      <= rem_nxt;
    step_r     <= step_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_DIV) |-> (rem_r < div_r))
    else $error("partial remainder not below the frame count");

  a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (state_r == BK_IDLE) && !q_stat.empty)
    else $error("queue popped outside the idle state");

endmodule

FILE: rtl/core/adts_header_parse_bitrate.sv
// Top level of the ADTS header parser with running average bitrate.
// The bit-serial divider produces one quotient bit per cycle over the COUNT_WIDTH + 23 bit
// product; a new word leaves the queue only once the result of the last one is in the
// output register.
// Two further words are taken into the queue while the divider is busy.
// Reset clears the length sum, the frame count, the queue and the output valid flag.
module adts_header_parse_bitrate
  import ahp_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  // header_bits
  input  logic [IN_W-1:0]  in_tdata,
  output logic             out_tvalid,
  input  logic             out_tready,
  // mpeg_version_bit, no_crc, object_type, rate_index, sample_rate_hz, channel_config,
  // frame_bytes, fullness, extra_blocks, is_vbr, avg_bitrate, zero fill
  output logic [OUT_W-1:0] out_tdata
);

  localparam int SUM_W = COUNT_WIDTH + FLEN_W;
  localparam int HDR_W = $bits(hdr_t);
  localparam int DATA_W = HDR_W + SUM_W + COUNT_WIDTH;

  q_stat_t                q_stat;
  logic                   push, pop;
  hdr_t                   push_hdr, pop_hdr;
  logic [SUM_W-1:0]       push_sum, pop_sum;
  logic [COUNT_WIDTH-1:0] push_count, pop_count;
  logic [DATA_W-1:0]      pop_data;

  ahp_front #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .q_stat     (q_stat),
    .push       (push),
    .push_hdr   (push_hdr),
    .push_sum   (push_sum),
    .push_count (push_count)
  );

  ahp_fifo #(
    .DATA_W(DATA_W)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data ({push_hdr, push_sum, push_count}),
    .pop       (pop),
    .pop_data  (pop_data),
    .stat      (q_stat)
  );

  assign pop_hdr   = pop_data[DATA_W-1:SUM_W+COUNT_WIDTH];
  assign pop_sum   = pop_data[SUM_W+COUNT_WIDTH-1:COUNT_WIDTH];
  assign pop_count = pop_data[COUNT_WIDTH-1:0];

  ahp_back #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_stat     (q_stat),
    .pop        (pop),
    .pop_hdr    (pop_hdr),
    .pop_sum    (pop_sum),
    .pop_count  (pop_count),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

FILE: tb/sv/adts_header_parse_bitrate_tb.sv
// Self-checking testbench of the ADTS header parser with running average bitrate.
module adts_header_parse_bitrate_tb;
  import ahp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int COUNT_W = COUNT_WIDTH_DEF;
  localparam int SUM_W = COUNT_W + FLEN_W;
  localparam logic [63:0] COUNT_MAX = (64'd1 << COUNT_W) - 64'd1;
  localparam logic [63:0] SUM_MAX = (64'd1 << SUM_W) - 64'd1;
  localparam int LATENCY = COUNT_W + 26;
  localparam int HOLD_CYCLES = 400;
  localparam int IDLE_LIMIT = 2000;
  localparam logic [11:0] SYNCWORD = 12'hFFF;
  localparam logic [3:0] LAST_VALID_IDX = 4'd12;
  localparam logic [3:0] RESERVED_IDX = 4'd13;
  localparam logic [FLEN_W-1:0] FLEN_MAX = 13'h1FFF;
  localparam int unsigned RATE_TABLE_HZ [16] = '{
    96000, 88200, 64000, 48000, 44100, 32000, 24000, 22050,
    16000, 12000, 11025, 8000, 7350, 0, 0, 0
  };

  typedef struct {
    logic              mpeg_version_bit;
    logic              no_crc;
    logic [2:0]        object_type;
    logic [3:0]        rate_index;
    logic [RATE_W-1:0] sample_rate_hz;
    logic [2:0]        channel_config;
    logic [FLEN_W-1:0] frame_bytes;
    logic [10:0]       fullness;
    logic [1:0]        extra_blocks;
    logic              is_vbr;
    logic [AVG_W-1:0]  avg_bitrate;
  } frame_report_t;

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            in_tvalid = 1'b0;
  logic            in_tready;
  logic [IN_W-1:0] in_tdata = '0;
  logic            out_tvalid;
  logic            out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;

  logic [63:0] length_sum;
  logic [63:0] frames_seen;
  frame_report_t pending_reports [$];

  int unsigned mismatch_count = 0;
  int unsigned headers_sent = 0;
  int unsigned reports_checked = 0;
  int unsigned idle_cycles = 0;
  int unsigned burst_left = 0;
  bit          tx_gaps_on = 1'b0;
  bit          rx_stalls_on = 1'b0;
  int unsigned hold_requests = 0;
  int unsigned hold_served = 0;
  int unsigned hold_left = 0;
  int unsigned rx_run_left = 0;
  bit          rx_run_ready = 1'b1;

  adts_header_parse_bitrate u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #1 clk = ~clk;

  function automatic logic [IN_W-1:0] make_header(
    input logic [11:0] sync, input logic id, input logic [1:0] layer, input logic pa,
    input logic [1:0] prof, input logic [3:0] idx, input logic priv, input logic [2:0] chan,
    input logic [3:0] misc, input logic [12:0] flen, input logic [10:0] full,
    input logic [1:0] blocks);
    return {sync, id, layer, pa, prof, idx, priv, chan, misc, flen, full, blocks};
  endfunction

  // Updates the running sum and count, then works out the report for one header.
  function automatic frame_report_t predict_report(input logic [IN_W-1:0] h);
    frame_report_t r;
    logic [63:0] rate;
    logic [63:0] k8;
    logic [63:0] q;
    logic [63:0] rem;
    logic [63:0] avg;
    r.mpeg_version_bit = h[43];
    r.no_crc = h[40];
    r.object_type = {1'b0, h[39:38]} + 3'd1;
    r.rate_index = h[37:34];
    r.channel_config = h[32:30];
    r.frame_bytes = h[25:13];
    r.fullness = h[12:2];
    r.extra_blocks = h[1:0];
    rate = 64'(RATE_TABLE_HZ[r.rate_index]);
    r.sample_rate_hz = rate[RATE_W-1:0];
    r.is_vbr = (r.fullness == VBR_MARK);
    if (frames_seen < COUNT_MAX) begin
      frames_seen = frames_seen + 64'd1;
      if (SUM_MAX - length_sum < 64'(r.frame_bytes)) begin
        length_sum = SUM_MAX;
      end else begin
        length_sum = length_sum + 64'(r.frame_bytes);
      end
    end
    avg = 64'd0;
    if (!r.is_vbr && frames_seen != 64'd0) begin
      k8 = (rate / 64'd1024) * 64'd8;
      q = length_sum / frames_seen;
      rem = length_sum % frames_seen;
      avg = k8 * q + (k8 * rem) / frames_seen;
    end
    r.avg_bitrate = avg[AVG_W-1:0];
    return r;
  endfunction

  function automatic frame_report_t unpack_report(input logic [OUT_W-1:0] d);
    frame_report_t r;
    r.mpeg_version_bit = d[0];
    r.no_crc = d[1];
    r.object_type = d[4:2];
    r.rate_index = d[8:5];
    r.sample_rate_hz = d[25:9];
    r.channel_config = d[28:26];
    r.frame_bytes = d[41:29];
    r.fullness = d[52:42];
    r.extra_blocks = d[54:53];
    r.is_vbr = d[55];
    r.avg_bitrate = d[78:56];
    return r;
  endfunction

  task automatic check_field(input string name, input longint unsigned want,
                             input longint unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  // Called at a falling edge; returns at the falling edge after the word is taken.
  task automatic send_header(input logic [IN_W-1:0] h);
    int unsigned gap;
    frame_report_t predicted;
    gap = 0;
    if (tx_gaps_on) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 12);
        gap = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 70) : $urandom_range(1, 8);
      end else begin
        burst_left--;
      end
    end
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= h;
    do @(posedge clk); while (!in_tready);
    predicted = predict_report(h);
    pending_reports = {pending_reports, predicted};
    headers_sent++;
    @(negedge clk);
  endtask

  function automatic logic [IN_W-1:0] random_header();
    logic [12:0] flen;
    logic [10:0] full;
    if ($urandom_range(0, 9) < 3) begin
      return {24'($urandom), 32'($urandom)};
    end
    flen = ($urandom_range(0, 9) == 0) ? 13'($urandom) : 13'($urandom_range(7, 1800));
    full = ($urandom_range(0, 5) == 0) ? VBR_MARK : 11'($urandom_range(0, 2046));
    return make_header(SYNCWORD, 1'($urandom), 2'b00, 1'($urandom), 2'($urandom),
                       4'($urandom_range(0, LAST_VALID_IDX)), 1'($urandom), 3'($urandom),
                       4'($urandom), flen, full, 2'($urandom));
  endfunction

  task automatic test_field_extremes();
    send_header('0);
    send_header('1);
    send_header({7{8'hAA}});
    send_header({7{8'h55}});
    send_header(make_header(SYNCWORD, 1'b0, 2'b00, 1'b1, 2'd1, 4'd0, 1'b0, 3'd2, 4'd0,
                            FLEN_MAX, 11'd0, 2'd0));
    send_header(make_header(SYNCWORD, 1'b1, 2'b00, 1'b0, 2'd0, 4'd3, 1'b0, 3'd2, 4'd0,
                            13'd0, 11'h7FE, 2'd3));
    send_header(make_header(SYNCWORD, 1'b0, 2'b00, 1'b1, 2'd1, 4'd3, 1'b0, 3'd1, 4'd0,
                            13'd400, VBR_MARK, 2'd0));
    send_header(make_header(SYNCWORD, 1'b0, 2'b00, 1'b1, 2'd1, RESERVED_IDX, 1'b0, 3'd2,
                            4'd0, 13'd512, 11'd300, 2'd0));
  endtask

  task automatic test_rate_table();
    for (int i = 0; i < 16; i++) begin
      send_header(make_header(SYNCWORD, 1'(i), 2'b00, 1'(i >> 1), 2'(i), 4'(i), 1'b0,
                              3'(i), 4'(i), 13'(300 + 97 * i), 11'(100 * i), 2'(i)));
    end
  endtask

  task automatic test_output_hold();
    tx_gaps_on = 1'b0;
    hold_requests++;
    for (int i = 0; i < 12; i++) begin
      send_header(random_header());
    end
  endtask

  task automatic test_random_headers(input int unsigned count);
    for (int unsigned i = 0; i < count; i++) begin
      if (i % 170 == 0) begin
        tx_gaps_on = (i != 0) && ($urandom_range(0, 3) != 0);
        rx_stalls_on = (i != 0) && ($urandom_range(0, 3) != 0);
      end
      send_header(random_header());
    end
  endtask

  always @(negedge clk) begin
    if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (!rx_stalls_on) begin
      out_tready <= 1'b1;
    end else begin
      if (rx_run_left == 0) begin
        rx_run_ready = !rx_run_ready;
        rx_run_left = rx_run_ready ? $urandom_range(1, 24) : $urandom_range(1, 12);
      end
      rx_run_left--;
      out_tready <= rx_run_ready;
    end
  end

  always @(posedge clk) begin
    frame_report_t got;
    frame_report_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = unpack_report(out_tdata);
      if (pending_reports.size() == 0) begin
        $error("Unexpected output word: %h", out_tdata);
        mismatch_count++;
      end else begin
        want = pending_reports.pop_front();
        reports_checked++;
        check_field("mpeg_version_bit", want.mpeg_version_bit, got.mpeg_version_bit);
        check_field("no_crc", want.no_crc, got.no_crc);
        check_field("object_type", want.object_type, got.object_type);
        check_field("rate_index", want.rate_index, got.rate_index);
        check_field("sample_rate_hz", want.sample_rate_hz, got.sample_rate_hz);
        check_field("channel_config", want.channel_config, got.channel_config);
        check_field("frame_bytes", want.frame_bytes, got.frame_bytes);
        check_field("fullness", want.fullness, got.fullness);
        check_field("extra_blocks", want.extra_blocks, got.extra_blocks);
        check_field("is_vbr", want.is_vbr, got.is_vbr);
        check_field("avg_bitrate", want.avg_bitrate, got.avg_bitrate);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Watchdog expired with %0d words outstanding.", pending_reports.size());
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin
    length_sum = '0;
    frames_seen = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_field_extremes();
    test_rate_table();
    test_output_hold();
    test_random_headers(1360);
    in_tvalid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (LATENCY + 20) @(posedge clk);
    $display("Checked %0d reports from %0d headers: field extremes, the full rate table,",
             reports_checked, headers_sent);
    $display("VBR and reserved-rate frames, random headers and a long output stall.");
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
